FILE: rtl/spr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spr_pkg
// Shared types and constants for the speed ramp and PI current command block.
// ----------------------------------------------------------------------------
package spr_pkg;

    // Field widths
    localparam int SPEED_W  = 16;
    localparam int STEP_W   = 15;
    localparam int GAIN_W   = 20;
    localparam int LIMIT_W  = 17;
    localparam int INTEG_W  = 18;
    localparam int ERR_W    = SPEED_W + 1;
    localparam int SUM_W    = INTEG_W + 1;

    // Gain products and their Q15 terms
    localparam int GAIN_SHIFT   = 15;
    localparam int PROP_PROD_W  = ERR_W + GAIN_W + 1;
    localparam int INTEG_PROD_W = INTEG_W + GAIN_W + 1;
    localparam int PROP_TERM_W  = PROP_PROD_W - GAIN_SHIFT;
    localparam int INTEG_TERM_W = INTEG_PROD_W - GAIN_SHIFT;
    localparam int CMD_W        = INTEG_TERM_W + 1;

    // APB register port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;
    localparam int REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_ACCEL_STEP      = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_DECEL_STEP      = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_PROP_GAIN       = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_INTEG_GAIN      = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_INTEGRAL_LIMIT  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_COMMAND_MINIMUM = 3'd5;

    // Reset values
    localparam logic [STEP_W-1:0]         RST_ACCEL_STEP      = 15'd10;
    localparam logic [STEP_W-1:0]         RST_DECEL_STEP      = 15'd10;
    localparam logic [GAIN_W-1:0]         RST_PROP_GAIN       = 20'd64768;
    localparam logic [GAIN_W-1:0]         RST_INTEG_GAIN      = 20'd1400;
    localparam logic [LIMIT_W-1:0]        RST_INTEGRAL_LIMIT  = 17'd53000;
    localparam logic signed [SPEED_W-1:0] RST_COMMAND_MINIMUM = -16'sd2000;

    typedef logic signed [SPEED_W-1:0] t_speed;

    typedef struct packed {
        logic [STEP_W-1:0]         accel_step;
        logic [STEP_W-1:0]         decel_step;
        logic [GAIN_W-1:0]         prop_gain;
        logic [GAIN_W-1:0]         integ_gain;
        logic [LIMIT_W-1:0]        integral_limit;
        logic signed [SPEED_W-1:0] command_minimum;
    } t_cfg;

endpackage

FILE: rtl/spr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spr_in_if / spr_out_if
// Valid/ready channels for control ticks in and current commands out.
// ----------------------------------------------------------------------------
interface spr_in_if;
    import spr_pkg::*;

    logic   valid;
    logic   ready;
    logic   motor_enabled;
    logic   in_run_state;
    t_speed target_speed;
    t_speed measured_speed;

    modport source (
        output valid, motor_enabled, in_run_state, target_speed, measured_speed,
        input  ready
    );
    modport sink (
        input  valid, motor_enabled, in_run_state, target_speed, measured_speed,
        output ready
    );
endinterface

interface spr_out_if;
    import spr_pkg::*;

    logic   valid;
    logic   ready;
    logic   command_valid;
    t_speed current_command;
    logic   clear_current_integrals;
    t_speed speed_reference;

    modport source (
        output valid, command_valid, current_command, clear_current_integrals,
               speed_reference,
        input  ready
    );
    modport sink (
        input  valid, command_valid, current_command, clear_current_integrals,
               speed_reference,
        output ready
    );
endinterface

FILE: rtl/speed_ramp_pi_current_command.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// speed_ramp_pi_current_command
// Speed reference ramp and PI speed loop producing a q-axis current command.
// ----------------------------------------------------------------------------
// A tick is taken in every clock cycle while the pipeline can move. Its result
// passes through three register stages on its way to the output; the input
// transfer loads the first stage and the third is the output register. The
// ramp and the integral are updated at the transfer itself, so back-to-back
// ticks see each other's state. The second stage forms the two gain products,
// the third adds them and clamps the command into the output register.
// Registers are written over APB at byte address 4*index; write them only
// while no tick is in flight.
// ----------------------------------------------------------------------------
module speed_ramp_pi_current_command (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    spr_in_if.sink                         i_in,
    spr_out_if.source                      o_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [spr_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [spr_pkg::APB_DATA_W-1:0] pwdata,
    output logic [spr_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import spr_pkg::*;

    t_cfg w_cfg;

    spr_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Flow control
    logic r_v1, r_v2, r_v3;
    logic w_rdy1, w_rdy2, w_rdy3, w_acc;

    assign w_rdy3     = !r_v3 || o_out.ready;
    assign w_rdy2     = !r_v2 || w_rdy3;
    assign w_rdy1     = !r_v1 || w_rdy2;
    assign i_in.ready = w_rdy1;
    assign w_acc      = i_in.valid && w_rdy1;

    // Loop state
    logic signed [SPEED_W-1:0] r_ref, n_ref;
    logic signed [INTEG_W-1:0] r_integ, n_integ;

    // Stage 1: ramp, error and integral update
    logic signed [ERR_W-1:0]   w_diff, w_err, w_accel, w_decel_neg, w_step_sum;
    logic signed [SUM_W-1:0]   w_sum, w_lim, w_lim_neg;
    logic signed [INTEG_W-1:0] w_acc_clamped;
    logic                      w_zero;

    always_comb begin
        w_diff      = ERR_W'(i_in.target_speed) - ERR_W'(r_ref);
        w_accel     = $signed({2'b00, w_cfg.accel_step});
        w_decel_neg = -$signed({2'b00, w_cfg.decel_step});
        n_ref       = r_ref;
        w_step_sum  = '0;
        if (i_in.motor_enabled) begin
            if (w_diff > 0) begin
                w_step_sum = ERR_W'(r_ref) + w_accel;
                n_ref = (w_diff > w_accel) ? w_step_sum[SPEED_W-1:0] : i_in.target_speed;
            end else if (w_diff < 0) begin
                w_step_sum = ERR_W'(r_ref) + w_decel_neg;
                n_ref = (w_diff < w_decel_neg) ? w_step_sum[SPEED_W-1:0]
                                               : i_in.target_speed;
            end
        end

        w_zero    = (n_ref == '0);
        w_err     = ERR_W'(n_ref) - ERR_W'(i_in.measured_speed);
        w_sum     = SUM_W'(r_integ) + SUM_W'(w_err);
        w_lim     = $signed({2'b00, w_cfg.integral_limit});
        w_lim_neg = -w_lim;
        if (w_sum >= w_lim) begin
            w_acc_clamped = w_lim[INTEG_W-1:0];
        end else if (w_sum <= w_lim_neg) begin
            w_acc_clamped = w_lim_neg[INTEG_W-1:0];
        end else begin
            w_acc_clamped = w_sum[INTEG_W-1:0];
        end

        n_integ = r_integ;
        if (i_in.in_run_state) begin
            n_integ = w_zero ? '0 : w_acc_clamped;
        end
    end

    logic                      r1_run, r1_zero;
    logic signed [SPEED_W-1:0] r1_ref;
    logic signed [ERR_W-1:0]   r1_err;
    logic signed [INTEG_W-1:0] r1_acc;

    // Stage 2: gain products, floored Q15 terms
    logic signed [PROP_PROD_W-1:0]  w_prop_prod;
    logic signed [INTEG_PROD_W-1:0] w_integ_prod;

    assign w_prop_prod  = r1_err * $signed({1'b0, w_cfg.prop_gain});
    assign w_integ_prod = r1_acc * $signed({1'b0, w_cfg.integ_gain});

    logic                           r2_run, r2_zero;
    logic signed [SPEED_W-1:0]      r2_ref;
    logic signed [PROP_TERM_W-1:0]  r2_prop;
    logic signed [INTEG_TERM_W-1:0] r2_integ;

    // Stage 3: sum and clamp into [min(command_minimum, 0), 0]
    logic signed [CMD_W-1:0]   w_cmd_sum, w_lo;
    logic signed [SPEED_W-1:0] w_cmd;

    always_comb begin
        w_cmd_sum = CMD_W'(r2_prop) + CMD_W'(r2_integ);
        w_lo      = (w_cfg.command_minimum > 0) ? '0 : CMD_W'(w_cfg.command_minimum);
        if (!r2_run || r2_zero || w_cmd_sum >= 0) begin
            w_cmd = '0;
        end else if (w_cmd_sum <= w_lo) begin
            w_cmd = w_lo[SPEED_W-1:0];
        end else begin
            w_cmd = w_cmd_sum[SPEED_W-1:0];
        end
    end

    logic                      r3_valid_cmd, r3_clear;
    logic signed [SPEED_W-1:0] r3_cmd, r3_ref;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_ref   <= '0;
            r_integ <= '0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= i_in.valid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
            if (w_acc) begin
                r_ref   <= n_ref;
                r_integ <= n_integ;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r1_run  <= i_in.in_run_state;
            r1_zero <= w_zero;
            r1_ref  <= n_ref;
            r1_err  <= w_err;
            r1_acc  <= w_acc_clamped;
        end
        if (w_rdy2 && r_v1) begin
            r2_run   <= r1_run;
            r2_zero  <= r1_zero;
            r2_ref   <= r1_ref;
            r2_prop  <= w_prop_prod[PROP_PROD_W-1:GAIN_SHIFT];
            r2_integ <= w_integ_prod[INTEG_PROD_W-1:GAIN_SHIFT];
        end
        if (w_rdy3 && r_v2) begin
            r3_valid_cmd <= r2_run;
            r3_clear     <= r2_run && r2_zero;
            r3_cmd       <= w_cmd;
            r3_ref       <= r2_ref;
        end
    end

    assign o_out.valid                   = r_v3;
    assign o_out.command_valid           = r3_valid_cmd;
    assign o_out.current_command         = r3_cmd;
    assign o_out.clear_current_integrals = r3_clear;
    assign o_out.speed_reference         = r3_ref;

endmodule

FILE: rtl/spr_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spr_regs
// APB register file holding ramp steps, PI gains and clamp limits.
// ----------------------------------------------------------------------------
module spr_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [spr_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [spr_pkg::APB_DATA_W-1:0] pwdata,
    output logic [spr_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    output spr_pkg::t_cfg                  o_cfg
);
    import spr_pkg::*;

    t_cfg                 r_cfg;
    logic [REG_IDX_W-1:0] w_idx;
    logic                 w_wr;

    assign w_idx  = paddr[APB_ADDR_W-1:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.accel_step      <= RST_ACCEL_STEP;
            r_cfg.decel_step      <= RST_DECEL_STEP;
            r_cfg.prop_gain       <= RST_PROP_GAIN;
            r_cfg.integ_gain      <= RST_INTEG_GAIN;
            r_cfg.integral_limit  <= RST_INTEGRAL_LIMIT;
            r_cfg.command_minimum <= RST_COMMAND_MINIMUM;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_ACCEL_STEP:      r_cfg.accel_step      <= pwdata[STEP_W-1:0];
                REG_DECEL_STEP:      r_cfg.decel_step      <= pwdata[STEP_W-1:0];
                REG_PROP_GAIN:       r_cfg.prop_gain       <= pwdata[GAIN_W-1:0];
                REG_INTEG_GAIN:      r_cfg.integ_gain      <= pwdata[GAIN_W-1:0];
                REG_INTEGRAL_LIMIT:  r_cfg.integral_limit  <= pwdata[LIMIT_W-1:0];
                REG_COMMAND_MINIMUM: r_cfg.command_minimum <= pwdata[SPEED_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_ACCEL_STEP:
                prdata = {{(APB_DATA_W-STEP_W){1'b0}}, r_cfg.accel_step};
            REG_DECEL_STEP:
                prdata = {{(APB_DATA_W-STEP_W){1'b0}}, r_cfg.decel_step};
            REG_PROP_GAIN:
                prdata = {{(APB_DATA_W-GAIN_W){1'b0}}, r_cfg.prop_gain};
            REG_INTEG_GAIN:
                prdata = {{(APB_DATA_W-GAIN_W){1'b0}}, r_cfg.integ_gain};
            REG_INTEGRAL_LIMIT:
                prdata = {{(APB_DATA_W-LIMIT_W){1'b0}}, r_cfg.integral_limit};
            REG_COMMAND_MINIMUM:
                prdata = {{(APB_DATA_W-SPEED_W){r_cfg.command_minimum[SPEED_W-1]}},
                          r_cfg.command_minimum};
            default:
                prdata = '0;
        endcase
    end

endmodule
